// ===== hw/rtl/cdml_pkg.sv =====
package cdml_pkg;

    localparam int OPERAND_WIDTH_DEF = 8;
    localparam int MAX_RUN_DEF       = 64;
    localparam int VALUE_WIDTH       = 8;
    localparam int LIMIT_WIDTH       = 8;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 8'd100;

    typedef enum logic [1:0] {
        ST_VALUE = 2'd0,
        ST_NONE  = 2'd1,
        ST_ZERO  = 2'd2,
        ST_CUT   = 2'd3
    } status_t;

endpackage

// ===== hw/rtl/common_divisor_multiple_lister_top.sv =====
// Common divisor and common multiple lister.
// A command is one transfer on start while busy is low; it carries func and
// the two operands. Divisor mode lists every common divisor in ascending
// order, multiple mode lists every common multiple from 1 up to the limit
// register, or gives one "none" result when there is none. A zero operand
// gives one error result in the cycle after the transfer, with busy staying low.
// Results appear on found_value, result_status and last_of_run for exactly
// one cycle, marked by strobe, and the receiver cannot hold them off.
// Candidates are tested one after another by two bit-serial remainder units
// that run side by side over CW bits, where CW is the larger of
// OPERAND_WIDTH and 8, and each test ends in a decide step. A command walks
// the candidates from 1 up to top, the smaller operand or the limit. Each
// found value is shown when the next one is found, and the final one is
// shown from the flush state after the walk ends. A run stops at MAX_RUN
// values. The limit register is written with multiple_limit_we and resets
// to 100. Reset returns the block to idle with no result pending.
module common_divisor_multiple_lister_top #(
    parameter int OPERAND_WIDTH = cdml_pkg::OPERAND_WIDTH_DEF,
    parameter int MAX_RUN       = cdml_pkg::MAX_RUN_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               func,
    input  logic [OPERAND_WIDTH-1:0]           first_operand,
    input  logic [OPERAND_WIDTH-1:0]           second_operand,
    input  logic                               multiple_limit_we,
    input  logic [cdml_pkg::LIMIT_WIDTH-1:0]   multiple_limit_wdata,
    output logic                               strobe,
    output logic [cdml_pkg::VALUE_WIDTH-1:0]   found_value,
    output logic [1:0]                         result_status,
    output logic                               last_of_run
);

    localparam int CW    = (OPERAND_WIDTH > cdml_pkg::VALUE_WIDTH) ?
                           OPERAND_WIDTH : cdml_pkg::VALUE_WIDTH;
    localparam int BW    = $clog2(CW);
    localparam int CNT_W = $clog2(MAX_RUN + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DECIDE,
        S_FLUSH
    } state_t;

    state_t                           state_reg;
    logic [cdml_pkg::LIMIT_WIDTH-1:0] limit_reg;
    logic                             func_reg;
    logic [CW-1:0]                    a_reg;
    logic [CW-1:0]                    b_reg;
    logic [CW-1:0]                    top_reg;
    logic [CW-1:0]                    cand_reg;
    logic [CW-1:0]                    x0_reg;
    logic [CW-1:0]                    x1_reg;
    logic [CW-1:0]                    rem0_reg;
    logic [CW-1:0]                    rem1_reg;
    logic [BW-1:0]                    bit_cnt_reg;
    logic [CW-1:0]                    pend_reg;
    logic                             pend_valid_reg;
    logic                             cut_reg;
    logic [CNT_W-1:0]                 count_reg;
    logic                             strobe_reg;
    logic [cdml_pkg::VALUE_WIDTH-1:0] found_value_reg;
    cdml_pkg::status_t                status_reg;
    logic                             last_reg;

    logic [CW-1:0] a_in;
    logic [CW-1:0] b_in;
    logic [CW-1:0] top_in;
    logic [CW-1:0] d0;
    logic [CW-1:0] d1;
    logic [CW:0]   t0;
    logic [CW:0]   t1;
    logic [CW-1:0] rem0_next;
    logic [CW-1:0] rem1_next;
    logic [CW-1:0] cand_next;
    logic          hit;

    always_comb
    begin
        a_in   = CW'(first_operand);
        b_in   = CW'(second_operand);
        top_in = func ? CW'(limit_reg) : ((a_in < b_in) ? a_in : b_in);

        d0 = func_reg ? a_reg : cand_reg;
        d1 = func_reg ? b_reg : cand_reg;
        t0 = {rem0_reg, x0_reg[CW-1]};
        t1 = {rem1_reg, x1_reg[CW-1]};
        rem0_next = (t0 >= {1'b0, d0}) ? CW'(t0 - {1'b0, d0}) : CW'(t0);
        rem1_next = (t1 >= {1'b0, d1}) ? CW'(t1 - {1'b0, d1}) : CW'(t1);

        cand_next = cand_reg + CW'(1);
        hit       = (rem0_reg == '0) && (rem1_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            limit_reg       <= cdml_pkg::LIMIT_RESET;
            func_reg        <= 1'b0;
            a_reg           <= '0;
            b_reg           <= '0;
            top_reg         <= '0;
            cand_reg        <= '0;
            x0_reg          <= '0;
            x1_reg          <= '0;
            rem0_reg        <= '0;
            rem1_reg        <= '0;
            bit_cnt_reg     <= '0;
            pend_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            cut_reg         <= 1'b0;
            count_reg       <= '0;
            strobe_reg      <= 1'b0;
            found_value_reg <= '0;
            status_reg      <= cdml_pkg::ST_VALUE;
            last_reg        <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (multiple_limit_we)
            begin
                limit_reg <= multiple_limit_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        func_reg       <= func;
                        a_reg          <= a_in;
                        b_reg          <= b_in;
                        top_reg        <= top_in;
                        cand_reg       <= CW'(1);
                        x0_reg         <= func ? CW'(1) : a_in;
                        x1_reg         <= func ? CW'(1) : b_in;
                        rem0_reg       <= '0;
                        rem1_reg       <= '0;
                        bit_cnt_reg    <= BW'(CW - 1);
                        pend_valid_reg <= 1'b0;
                        cut_reg        <= 1'b0;
                        count_reg      <= '0;
                        if (a_in == '0 || b_in == '0)
                        begin
                            strobe_reg      <= 1'b1;
                            found_value_reg <= '0;
                            status_reg      <= cdml_pkg::ST_ZERO;
                            last_reg        <= 1'b1;
                        end
                        else if (top_in == '0)
                        begin
                            strobe_reg      <= 1'b1;
                            found_value_reg <= '0;
                            status_reg      <= cdml_pkg::ST_NONE;
                            last_reg        <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_CHECK:
                begin
                    rem0_reg    <= rem0_next;
                    rem1_reg    <= rem1_next;
                    x0_reg      <= {x0_reg[CW-2:0], 1'b0};
                    x1_reg      <= {x1_reg[CW-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg - BW'(1);
                    if (bit_cnt_reg == '0)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            strobe_reg      <= 1'b1;
                            found_value_reg <= pend_reg[cdml_pkg::VALUE_WIDTH-1:0];
                            status_reg      <= cdml_pkg::ST_VALUE;
                            last_reg        <= 1'b0;
                        end
                        pend_reg       <= cand_reg;
                        pend_valid_reg <= 1'b1;
                        count_reg      <= count_reg + CNT_W'(1);
                    end
                    if (hit && count_reg == CNT_W'(MAX_RUN - 1))
                    begin
                        cut_reg   <= 1'b1;
                        state_reg <= S_FLUSH;
                    end
                    else if (cand_reg == top_reg)
                    begin
                        state_reg <= S_FLUSH;
                    end
                    else
                    begin
                        cand_reg    <= cand_next;
                        x0_reg      <= func_reg ? cand_next : a_reg;
                        x1_reg      <= func_reg ? cand_next : b_reg;
                        rem0_reg    <= '0;
                        rem1_reg    <= '0;
                        bit_cnt_reg <= BW'(CW - 1);
                        state_reg   <= S_CHECK;
                    end
                end
                S_FLUSH:
                begin
                    strobe_reg <= 1'b1;
                    last_reg   <= 1'b1;
                    if (pend_valid_reg)
                    begin
                        found_value_reg <= pend_reg[cdml_pkg::VALUE_WIDTH-1:0];
                        status_reg      <= cut_reg ? cdml_pkg::ST_CUT : cdml_pkg::ST_VALUE;
                    end
                    else
                    begin
                        found_value_reg <= '0;
                        status_reg      <= cdml_pkg::ST_NONE;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign strobe        = strobe_reg;
    assign found_value   = found_value_reg;
    assign result_status = status_reg;
    assign last_of_run   = last_reg;

`ifndef ASSERT_OFF
    a_special_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result_status != cdml_pkg::ST_VALUE) |-> last_of_run)
        else $error("A cut, none or error result was not marked last.");

    a_special_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result_status == cdml_pkg::ST_NONE ||
                   result_status == cdml_pkg::ST_ZERO) |-> (found_value == '0))
        else $error("A none or error result carried a nonzero value.");

    a_zero_operand: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (first_operand == '0 || second_operand == '0)
        |=> strobe && (result_status == cdml_pkg::ST_ZERO) && !busy)
        else $error("A zero operand did not give an immediate error result.");

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RUN))
        else $error("The run count passed its maximum.");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_of_run |-> !busy)
        else $error("A last result was shown while the walk was still running.");
`endif

endmodule
